// ===== hw/rtl/mahd_pkg.sv =====
package mahd_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_FREE = 2'd1,
		STATUS_BAD  = 2'd2
	} status_t;

	// header fields carried down the pipe
	typedef struct packed {
		logic       bad;
		logic       free_fmt;
		logic [1:0] layer;
		logic       lsf;
		logic       v25;
		logic [1:0] sri;
		logic       pad;
		logic [1:0] mode;
		logic [1:0] joint_ext;
		logic       crc;
		logic [8:0] kbps;
	} hdr_info_t;

	localparam int KBPS_W  = 9;
	localparam int SHIFT_W = 11;
	localparam int PROD_W  = 17;
	localparam int RECIP_W = 25;
	localparam int QUOT_W  = 11;
	localparam int RECIP_SHIFT = 24;

	// reciprocals scaled by 2^24, exact for dividends below 2^17
	localparam logic [RECIP_W-1:0] RECIP_49  = 25'd342393;
	localparam logic [RECIP_W-1:0] RECIP_147 = 25'd114131;
	localparam logic [RECIP_W-1:0] RECIP_1   = 25'd16777216;
	localparam logic [RECIP_W-1:0] RECIP_2   = 25'd8388608;
	localparam logic [RECIP_W-1:0] RECIP_4   = 25'd4194304;
	localparam logic [RECIP_W-1:0] RECIP_8   = 25'd2097152;

	localparam logic [10:0] SPF_LAYER1 = 11'd384;
	localparam logic [10:0] SPF_FULL   = 11'd1152;
	localparam logic [10:0] SPF_HALF   = 11'd576;

	localparam logic [9:0] BPS_PER_KBPS = 10'd1000;

	localparam logic [1:0] SRI_44K = 2'd0;
	localparam logic [1:0] SRI_48K = 2'd1;
	localparam logic [1:0] SRI_32K = 2'd2;
	localparam logic [1:0] MODE_MONO = 2'd3;
	localparam logic [1:0] VER_RESERVED = 2'd1;

	// kbit/s indexed [lsf][layer code][bitrate index], layer code 3 is layer 1
	localparam logic [8:0] KBPS_TAB [2][4][16] = '{
		'{
			'{16{9'd0}},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
				9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
				9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
		},
		'{
			'{16{9'd0}},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
		}
	};

	// base sampling frequency of the full-rate version
	function automatic logic [15:0] base_freq(logic [1:0] sri);
		logic [15:0] f;
		case (sri)
			SRI_44K: f = 16'd44100;
			SRI_48K: f = 16'd48000;
			SRI_32K: f = 16'd32000;
			default: f = 16'd0;
		endcase
		return f;
	endfunction

endpackage

// ===== hw/rtl/mahd_decode.sv =====
module mahd_decode
	import mahd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        header_valid,
	output logic        header_ready,
	input  logic [31:0] header_word,
	output logic        info_valid,
	input  logic        info_ready,
	output hdr_info_t   info
);

	logic       v_s1;
	hdr_info_t  info_s1;
	hdr_info_t  info_d;
	logic [1:0] ver;
	logic [1:0] lcode;
	logic [3:0] bri;
	logic [1:0] sri;
	logic       ok;
	logic       lsf;

	// field split and header checks
	always_comb begin
		ver   = header_word[20:19];
		lcode = header_word[18:17];
		bri   = header_word[15:12];
		sri   = header_word[11:10];
		ok    = (&header_word[31:21]) && (ver != VER_RESERVED) && (lcode != 2'd0)
			&& (bri != 4'hf) && (sri != 2'd3);
		lsf   = header_word[20] ? ~header_word[19] : 1'b1;
		info_d.bad       = ~ok;
		info_d.free_fmt  = (bri == 4'd0);
		info_d.layer     = 2'(3'd4 - {1'b0, lcode});
		info_d.lsf       = lsf;
		info_d.v25       = ~header_word[20];
		info_d.sri       = sri;
		info_d.pad       = header_word[9];
		info_d.mode      = header_word[7:6];
		info_d.joint_ext = header_word[5:4];
		info_d.crc       = ~header_word[16];
		info_d.kbps      = KBPS_TAB[lsf][lcode][bri];
	end

	assign header_ready = ~v_s1 | info_ready;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (header_ready) begin
			v_s1 <= header_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (header_valid && header_ready) begin
			info_s1 <= info_d;
		end
	end

	assign info_valid = v_s1;
	assign info       = info_s1;

endmodule

// ===== hw/rtl/mahd_size.sv =====
module mahd_size
	import mahd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              info_valid,
	output logic              info_ready,
	input  hdr_info_t         info,
	output logic              quot_valid,
	input  logic              quot_ready,
	output logic [QUOT_W-1:0] quot,
	output hdr_info_t         quot_info
);

	logic               v_s2;
	logic               v_s3;
	logic               ready_s2;
	logic               ready_s3;
	hdr_info_t          info_s2;
	hdr_info_t          info_s3;
	logic [PROD_W-1:0]  dvd_s2;
	logic [RECIP_W-1:0] recip_s2;
	logic [QUOT_W-1:0]  quot_s3;

	logic [1:0]         sh;
	logic [SHIFT_W-1:0] kbps_sh;
	logic [7:0]         mult;
	logic [RECIP_W-1:0] recip;
	logic [SHIFT_W+7:0] dvd_full;
	logic               is_l1;
	logic [PROD_W+RECIP_W-1:0] prod;

	// dividend: kbps scaled by 2^shift and the per-rate numerator factor
	always_comb begin
		is_l1 = (info.layer == 2'd1);
		sh = 2'({1'b0, info.lsf} + {1'b0, info.v25}
			- {1'b0, (info.layer == 2'd3) & info.lsf});
		kbps_sh = {2'b00, info.kbps} << sh;
		case (info.sri)
			SRI_44K: begin
				mult  = is_l1 ? 8'd40 : 8'd160;
				recip = is_l1 ? RECIP_147 : RECIP_49;
			end
			SRI_48K: begin
				mult  = is_l1 ? 8'd1 : 8'd3;
				recip = is_l1 ? RECIP_4 : RECIP_1;
			end
			SRI_32K: begin
				mult  = is_l1 ? 8'd3 : 8'd9;
				recip = is_l1 ? RECIP_8 : RECIP_2;
			end
			default: begin
				mult  = 8'd0;
				recip = RECIP_1;
			end
		endcase
		dvd_full = kbps_sh * mult;
	end

	// quotient by reciprocal multiply
	always_comb begin
		prod = dvd_s2 * recip_s2;
	end

	assign ready_s3   = ~v_s3 | quot_ready;
	assign ready_s2   = ~v_s2 | ready_s3;
	assign info_ready = ready_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= info_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (info_valid && ready_s2) begin
			info_s2  <= info;
			dvd_s2   <= dvd_full[PROD_W-1:0];
			recip_s2 <= recip;
		end
		if (v_s2 && ready_s3) begin
			info_s3 <= info_s2;
			quot_s3 <= prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
		end
	end

	assign quot_valid = v_s3;
	assign quot       = quot_s3;
	assign quot_info  = info_s3;

endmodule

// ===== hw/rtl/mpeg_audio_header_decode_core.sv =====
// MPEG audio frame header decoder, layers 1 to 3, MPEG-1, MPEG-2 and MPEG-2.5.
// Input channel: header_valid / header_ready carry one 32-bit header a beat,
// sync bits in the top. Output channel: result_valid / result_ready carry one
// decoded result a beat: status, layer, rate fields, bit rate, frame size,
// samples per frame and channel layout. Invalid headers give status 2 with
// all other fields zero; free-format headers give status 1 with zero sizes.
// An accepted header passes four registered stages to result_valid: field
// decode and bitrate lookup, dividend scaling, reciprocal multiply for the
// frame size division, and the output register. The four-stage pipe, with at
// most one multiplier per stage, takes one header per cycle unless stalled.
// Reset clears every stage valid bit, so no result appears until a header
// is accepted. When the receiver holds result_ready low, the output beat
// holds and earlier stages keep filling their empty slots; header_ready falls
// only once all four stages hold a beat, and nothing is dropped or repeated.
module mpeg_audio_header_decode_core
	import mahd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        header_valid,
	output logic        header_ready,
	input  logic [31:0] header_word,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [1:0]  layer,
	output logic        low_rate_flag,
	output logic [3:0]  rate_index,
	output logic [15:0] sample_rate_hz,
	output logic [18:0] bit_rate_bps,
	output logic [10:0] frame_size_bytes,
	output logic [10:0] samples_per_frame,
	output logic [1:0]  channel_count,
	output logic [1:0]  channel_mode,
	output logic [1:0]  mode_extension,
	output logic        crc_present
);

	logic              info_valid;
	logic              info_ready;
	hdr_info_t         info;
	logic              quot_valid;
	logic              quot_ready;
	logic [QUOT_W-1:0] quot;
	hdr_info_t         qi;

	logic              v_s4;
	status_t           status_s4;
	logic [1:0]        layer_s4;
	logic              lsf_s4;
	logic [3:0]        rate_index_s4;
	logic [15:0]       sample_rate_s4;
	logic [18:0]       bps_s4;
	logic [10:0]       fsz_s4;
	logic [10:0]       spf_s4;
	logic [1:0]        chan_count_s4;
	logic [1:0]        mode_s4;
	logic [1:0]        joint_ext_s4;
	logic              crc_s4;

	status_t           status_d;
	logic [1:0]        layer_d;
	logic              lsf_d;
	logic [3:0]        rate_index_d;
	logic [15:0]       sample_rate_d;
	logic [18:0]       bps_d;
	logic [10:0]       fsz_d;
	logic [10:0]       spf_d;
	logic [1:0]        chan_count_d;
	logic [1:0]        mode_d;
	logic [1:0]        joint_ext_d;
	logic              crc_d;
	logic [QUOT_W-1:0] qpad;
	logic [1:0]        steps;

	mahd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.header_valid (header_valid),
		.header_ready (header_ready),
		.header_word  (header_word),
		.info_valid   (info_valid),
		.info_ready   (info_ready),
		.info         (info)
	);

	mahd_size u_size (
		.clk        (clk),
		.arst_n     (arst_n),
		.info_valid (info_valid),
		.info_ready (info_ready),
		.info       (info),
		.quot_valid (quot_valid),
		.quot_ready (quot_ready),
		.quot       (quot),
		.quot_info  (qi)
	);

	// result assembly
	always_comb begin
		steps = 2'({1'b0, qi.lsf} + {1'b0, qi.v25});
		qpad  = QUOT_W'(quot + {{(QUOT_W-1){1'b0}}, qi.pad});
		status_d      = qi.free_fmt ? STATUS_FREE : STATUS_OK;
		layer_d       = qi.layer;
		lsf_d         = qi.lsf;
		rate_index_d  = 4'({2'b00, qi.sri} + 4'(3 * steps));
		sample_rate_d = base_freq(qi.sri) >> steps;
		bps_d         = 19'(qi.kbps * BPS_PER_KBPS);
		if (qi.free_fmt) begin
			fsz_d = 11'd0;
		end else if (qi.layer == 2'd1) begin
			fsz_d = 11'({qpad, 2'b00});
		end else begin
			fsz_d = qpad;
		end
		if (qi.layer == 2'd1) begin
			spf_d = SPF_LAYER1;
		end else if (qi.layer == 2'd3 && qi.lsf) begin
			spf_d = SPF_HALF;
		end else begin
			spf_d = SPF_FULL;
		end
		chan_count_d = (qi.mode == MODE_MONO) ? 2'd1 : 2'd2;
		mode_d       = qi.mode;
		joint_ext_d  = qi.joint_ext;
		crc_d        = qi.crc;
		// invalid header clears everything but the status
		if (qi.bad) begin
			status_d      = STATUS_BAD;
			layer_d       = 2'd0;
			lsf_d         = 1'b0;
			rate_index_d  = 4'd0;
			sample_rate_d = 16'd0;
			bps_d         = 19'd0;
			fsz_d         = 11'd0;
			spf_d         = 11'd0;
			chan_count_d  = 2'd0;
			mode_d        = 2'd0;
			joint_ext_d   = 2'd0;
			crc_d         = 1'b0;
		end
	end

	assign quot_ready = ~v_s4 | result_ready;

	// output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (quot_ready) begin
			v_s4 <= quot_valid;
		end
	end

	// output stage payload
	always_ff @(posedge clk) begin
		if (quot_valid && quot_ready) begin
			status_s4      <= status_d;
			layer_s4       <= layer_d;
			lsf_s4         <= lsf_d;
			rate_index_s4  <= rate_index_d;
			sample_rate_s4 <= sample_rate_d;
			bps_s4         <= bps_d;
			fsz_s4         <= fsz_d;
			spf_s4         <= spf_d;
			chan_count_s4  <= chan_count_d;
			mode_s4        <= mode_d;
			joint_ext_s4   <= joint_ext_d;
			crc_s4         <= crc_d;
		end
	end

	assign result_valid      = v_s4;
	assign status            = status_s4;
	assign layer             = layer_s4;
	assign low_rate_flag     = lsf_s4;
	assign rate_index        = rate_index_s4;
	assign sample_rate_hz    = sample_rate_s4;
	assign bit_rate_bps      = bps_s4;
	assign frame_size_bytes  = fsz_s4;
	assign samples_per_frame = spf_s4;
	assign channel_count     = chan_count_s4;
	assign channel_mode      = mode_s4;
	assign mode_extension    = joint_ext_s4;
	assign crc_present       = crc_s4;

endmodule
